// File: src/acpc_pkg.sv
package acpc_pkg;

    // field widths
    localparam int CMD_W        = 3;
    localparam int LEVEL_W      = 8;
    localparam int PCT_W        = 7;
    localparam int PHASE_W      = 2;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int TIMER_W      = 16;
    localparam int LEAD_W       = 12;
    localparam int TIMEOUT_W    = 24;
    localparam int ACC_W        = 8;

    localparam int ELAPSED_WIDTH_DEFAULT = 24;

    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
    localparam logic [TIMER_W-1:0] COMPARE_OFF = 16'hFFFF;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_ZERO_CROSS = 3'd1,
        CMD_SET_PHASE  = 3'd2,
        CMD_SET_CYCLE  = 3'd3,
        CMD_AC_CHECK   = 3'd4
    } acpc_cmd_t;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAINS_60HZ   = 3'd0,
        CFG_LEAD         = 3'd1,
        CFG_PULSE_TICKS  = 3'd2,
        CFG_DENOMINATOR  = 3'd3,
        CFG_TIMEOUT      = 3'd4
    } acpc_cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_DELAYING = 2'd0,
        PH_PULSE_ON = 2'd1,
        PH_DISABLED = 2'd2
    } acpc_phase_t;

    typedef struct packed {
        logic                 mains_is_60hz;
        logic [LEAD_W-1:0]    zero_cross_lead;
        logic [TIMER_W-1:0]   triac_pulse_ticks;
        logic [PCT_W-1:0]     cycle_ratio_denominator;
        logic [TIMEOUT_W-1:0] ac_timeout_ticks;
    } acpc_cfg_t;

    // one decoded item, strobes high only in the cycle it is processed
    typedef struct packed {
        logic             tick;
        logic             zero_cross;
        logic             set_phase;
        logic             set_cycle;
        logic             ac_check;
        logic [PCT_W-1:0] level;
    } acpc_step_t;

    localparam logic [TIMER_W-1:0] DELAY_50HZ [0:100] = '{
        16'd20000, 16'd17680, 16'd17061, 16'd16621, 16'd16265, 16'd15961, 16'd15692,
        16'd15448, 16'd15225, 16'd15017, 16'd14822, 16'd14638, 16'd14462, 16'd14295,
        16'd14134, 16'd13979, 16'd13830, 16'd13685, 16'd13544, 16'd13407, 16'd13274,
        16'd13143, 16'd13016, 16'd12891, 16'd12768, 16'd12647, 16'd12529, 16'd12412,
        16'd12297, 16'd12184, 16'd12072, 16'd11961, 16'd11851, 16'd11743, 16'd11636,
        16'd11529, 16'd11423, 16'd11319, 16'd11215, 16'd11111, 16'd11008, 16'd10906,
        16'd10804, 16'd10703, 16'd10602, 16'd10501, 16'd10401, 16'd10300, 16'd10200,
        16'd10100, 16'd10000, 16'd9900,  16'd9800,  16'd9700,  16'd9599,  16'd9499,
        16'd9398,  16'd9297,  16'd9196,  16'd9094,  16'd8992,  16'd8889,  16'd8785,
        16'd8681,  16'd8577,  16'd8471,  16'd8364,  16'd8257,  16'd8149,  16'd8039,
        16'd7928,  16'd7816,  16'd7703,  16'd7588,  16'd7471,  16'd7353,  16'd7232,
        16'd7109,  16'd6984,  16'd6857,  16'd6726,  16'd6593,  16'd6456,  16'd6315,
        16'd6170,  16'd6021,  16'd5866,  16'd5705,  16'd5538,  16'd5362,  16'd5178,
        16'd4983,  16'd4775,  16'd4552,  16'd4308,  16'd4039,  16'd3735,  16'd3379,
        16'd2939,  16'd2320,  16'd0
    };

    localparam logic [TIMER_W-1:0] DELAY_60HZ [0:100] = '{
        16'd16667, 16'd14733, 16'd14218, 16'd13851, 16'd13554, 16'd13301, 16'd13076,
        16'd12874, 16'd12687, 16'd12514, 16'd12352, 16'd12198, 16'd12052, 16'd11912,
        16'd11778, 16'd11649, 16'd11525, 16'd11404, 16'd11287, 16'd11173, 16'd11061,
        16'd10953, 16'd10846, 16'd10742, 16'd10640, 16'd10540, 16'd10441, 16'd10343,
        16'd10248, 16'd10153, 16'd10060, 16'd9967,  16'd9876,  16'd9786,  16'd9696,
        16'd9608,  16'd9520,  16'd9432,  16'd9346,  16'd9259,  16'd9174,  16'd9088,
        16'd9004,  16'd8919,  16'd8835,  16'd8751,  16'd8667,  16'd8584,  16'd8500,
        16'd8417,  16'd8333,  16'd8250,  16'd8167,  16'd8083,  16'd8000,  16'd7916,
        16'd7832,  16'd7748,  16'd7663,  16'd7578,  16'd7493,  16'd7407,  16'd7321,
        16'd7234,  16'd7147,  16'd7059,  16'd6970,  16'd6881,  16'd6791,  16'd6699,
        16'd6607,  16'd6514,  16'd6419,  16'd6323,  16'd6226,  16'd6127,  16'd6027,
        16'd5924,  16'd5820,  16'd5714,  16'd5605,  16'd5494,  16'd5380,  16'd5263,
        16'd5142,  16'd5017,  16'd4888,  16'd4754,  16'd4615,  16'd4469,  16'd4315,
        16'd4153,  16'd3979,  16'd3793,  16'd3590,  16'd3366,  16'd3113,  16'd2816,
        16'd2449,  16'd1933,  16'd0
    };

    // linearised firing delay for a percent level
    function automatic logic [TIMER_W-1:0] delay_ticks(input logic is_60hz,
                                                       input logic [PCT_W-1:0] pct);
        logic [TIMER_W-1:0] d;
        d = '0;
        if (pct <= PCT_MAX)
        begin
            d = is_60hz ? DELAY_60HZ[pct] : DELAY_50HZ[pct];
        end
        return d;
    endfunction

endpackage

// File: src/acpc_if.sv
interface acpc_item_if;
    logic                            valid;
    logic                            ready;
    logic [acpc_pkg::CMD_W-1:0]      cmd;
    logic [acpc_pkg::LEVEL_W-1:0]    level;

    modport source (output valid, output cmd, output level, input ready);
    modport sink   (input valid, input cmd, input level, output ready);
endinterface

interface acpc_result_if;
    logic                            valid;
    logic                            ready;
    logic                            phase_drive;
    logic                            cycle_drive;
    logic                            ac_present;
    logic [acpc_pkg::PHASE_W-1:0]    phase_state;

    modport source (output valid, output phase_drive, output cycle_drive,
                    output ac_present, output phase_state, input ready);
    modport sink   (input valid, input phase_drive, input cycle_drive,
                    input ac_present, input phase_state, output ready);
endinterface

interface acpc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [acpc_pkg::CFG_INDEX_W-1:0]   index;
    logic [acpc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/acpc_phase_ctrl.sv
module acpc_phase_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  acpc_pkg::acpc_step_t             step,
    input  acpc_pkg::acpc_cfg_t              cfg,
    input  logic                             output_enable,
    output logic                             pin_next,
    output acpc_pkg::acpc_phase_t            phase_next
);

    acpc_pkg::acpc_phase_t                 phase_reg;
    logic [acpc_pkg::TIMER_W-1:0]          count_reg;
    logic [acpc_pkg::TIMER_W-1:0]          count_next;
    logic [acpc_pkg::TIMER_W-1:0]          compare_reg;
    logic [acpc_pkg::TIMER_W-1:0]          compare_next;
    logic [acpc_pkg::PCT_W-1:0]            level_reg;
    logic [acpc_pkg::PCT_W-1:0]            level_next;
    logic                                  pin_reg;
    logic [acpc_pkg::TIMER_W-1:0]          count_inc;
    logic [acpc_pkg::TIMER_W-1:0]          fire_delay;

    assign count_inc  = count_reg + 16'd1;
    assign fire_delay = acpc_pkg::delay_ticks(cfg.mains_is_60hz, level_reg)
                      + {{(acpc_pkg::TIMER_W - acpc_pkg::LEAD_W){1'b0}}, cfg.zero_cross_lead};

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        compare_next = compare_reg;
        level_next   = level_reg;
        pin_next     = pin_reg;

        if (step.tick)
        begin
            count_next = count_inc;
            if (count_inc == compare_reg)
            begin
                unique case (phase_reg)
                    acpc_pkg::PH_DELAYING:
                    begin
                        phase_next   = acpc_pkg::PH_PULSE_ON;
                        pin_next     = output_enable ? 1'b1 : pin_reg;
                        count_next   = '0;
                        compare_next = cfg.triac_pulse_ticks;
                    end
                    acpc_pkg::PH_PULSE_ON:
                    begin
                        phase_next   = acpc_pkg::PH_DISABLED;
                        pin_next     = 1'b0;
                        count_next   = '0;
                        compare_next = acpc_pkg::COMPARE_OFF;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (step.zero_cross)
        begin
            count_next   = '0;
            phase_next   = acpc_pkg::PH_DELAYING;
            pin_next     = output_enable ? 1'b0 : pin_reg;
            compare_next = fire_delay;
        end

        if (step.set_phase)
        begin
            level_next = step.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= acpc_pkg::PH_DISABLED;
            count_reg   <= '0;
            compare_reg <= acpc_pkg::COMPARE_OFF;
            level_reg   <= '0;
            pin_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            compare_reg <= compare_next;
            level_reg   <= level_next;
            pin_reg     <= pin_next;
        end
    end

endmodule

// File: src/acpc_cycle_ctrl.sv
module acpc_cycle_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  acpc_pkg::acpc_step_t             step,
    input  logic [acpc_pkg::PCT_W-1:0]       denominator,
    input  logic                             output_enable,
    output logic                             pin_next
);

    logic [acpc_pkg::PCT_W-1:0]  level_reg;
    logic [acpc_pkg::PCT_W-1:0]  level_next;
    logic                        restart_reg;
    logic                        restart_next;
    logic [acpc_pkg::ACC_W-1:0]  acc_reg;
    logic [acpc_pkg::ACC_W-1:0]  acc_next;
    logic                        pin_reg;
    logic [acpc_pkg::ACC_W-1:0]  half_sum;
    logic [acpc_pkg::ACC_W-1:0]  acc_start;
    logic [acpc_pkg::ACC_W-1:0]  acc_added;
    logic [acpc_pkg::ACC_W-1:0]  level_ext;
    logic [acpc_pkg::ACC_W-1:0]  denom_ext;

    assign level_ext = {1'b0, level_reg};
    assign denom_ext = {1'b0, denominator};
    // (n + m) / 2, then negated to seed a fresh sequence
    assign half_sum  = (level_ext + denom_ext) >> 1;
    assign acc_start = restart_reg ? (8'd0 - half_sum) : acc_reg;
    assign acc_added = acc_start + level_ext;

    always_comb
    begin
        level_next   = level_reg;
        restart_next = restart_reg;
        acc_next     = acc_reg;
        pin_next     = pin_reg;

        if (step.zero_cross)
        begin
            restart_next = 1'b0;
            if (!acc_added[acpc_pkg::ACC_W-1])
            begin
                acc_next = acc_added - denom_ext;
                pin_next = output_enable ? 1'b1 : pin_reg;
            end
            else
            begin
                acc_next = acc_added;
                pin_next = 1'b0;
            end
        end

        if (step.set_cycle)
        begin
            level_next   = step.level;
            restart_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            restart_reg <= 1'b1;
            acc_reg     <= '0;
            pin_reg     <= 1'b0;
        end
        else
        begin
            level_reg   <= level_next;
            restart_reg <= restart_next;
            acc_reg     <= acc_next;
            pin_reg     <= pin_next;
        end
    end

endmodule

// File: src/ac_phase_and_cycle_power_control.sv
// channel  | modport | payload                                        | beat
// ---------+---------+------------------------------------------------+---------------------
// item     | sink    | cmd, level                                     | one command
// result   | source  | phase_drive, cycle_drive, ac_present, phase_state | state after a command
// cfg      | sink    | index, data                                    | one register write
//
// one command per cycle sustained while result.ready stays high; a taken command moves from
// the input register to the result register, from which its result beat goes out, once no
// unaccepted beat waits there; the state update is one pass of logic between those registers
// reset clears both valid flags and returns all controller state to its power-up value
// while a result waits, one further command is held in the input register and item.ready
// drops; cfg.ready is always high
module ac_phase_and_cycle_power_control
#(
    parameter int ELAPSED_WIDTH = acpc_pkg::ELAPSED_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    acpc_item_if.sink             item,
    acpc_result_if.source         result,
    acpc_cfg_if.sink              cfg
);

    // compare width wide enough for both the elapsed count and the timeout
    localparam int CMP_W = (ELAPSED_WIDTH > acpc_pkg::TIMEOUT_W) ?
                           ELAPSED_WIDTH : acpc_pkg::TIMEOUT_W;

    // configuration registers
    acpc_pkg::acpc_cfg_t              cfg_reg;

    // input register
    logic                             in_valid_reg;
    logic [acpc_pkg::CMD_W-1:0]       cmd_reg;
    logic [acpc_pkg::LEVEL_W-1:0]     level_reg;

    // result register
    logic                             res_valid_reg;
    logic                             phase_drive_reg;
    logic                             cycle_drive_reg;
    logic                             ac_present_reg;
    logic [acpc_pkg::PHASE_W-1:0]     phase_state_reg;

    // presence tracking
    logic [ELAPSED_WIDTH-1:0]         elapsed_reg;
    logic [ELAPSED_WIDTH-1:0]         elapsed_next;
    logic                             enable_reg;
    logic                             enable_next;

    logic                             res_free;
    logic                             advance;
    logic [acpc_pkg::PCT_W-1:0]       level_clip;
    acpc_pkg::acpc_step_t             step;
    logic                             phase_pin_next;
    logic                             cycle_pin_next;
    acpc_pkg::acpc_phase_t            phase_next;
    logic                             in_time;

    assign res_free   = !res_valid_reg || result.ready;
    assign advance    = in_valid_reg && res_free;
    assign item.ready = !in_valid_reg || res_free;
    assign cfg.ready  = 1'b1;

    // levels above full power mean off
    assign level_clip = (level_reg > {1'b0, acpc_pkg::PCT_MAX}) ?
                        '0 : level_reg[acpc_pkg::PCT_W-1:0];

    // command decode, strobes only while the held command moves on
    always_comb
    begin
        step       = '0;
        step.level = level_clip;
        if (advance)
        begin
            unique case (cmd_reg)
                acpc_pkg::CMD_TICK:       step.tick       = 1'b1;
                acpc_pkg::CMD_ZERO_CROSS: step.zero_cross = 1'b1;
                acpc_pkg::CMD_SET_PHASE:  step.set_phase  = 1'b1;
                acpc_pkg::CMD_SET_CYCLE:  step.set_cycle  = 1'b1;
                acpc_pkg::CMD_AC_CHECK:   step.ac_check   = 1'b1;
                default:                  step.tick       = 1'b0;
            endcase
        end
    end

    // saturating count of ticks since the last crossing
    assign in_time = CMP_W'(elapsed_reg) <= CMP_W'(cfg_reg.ac_timeout_ticks);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        enable_next  = enable_reg;
        if (step.tick && !(&elapsed_reg))
        begin
            elapsed_next = elapsed_reg + ELAPSED_WIDTH'(1);
        end
        if (step.zero_cross)
        begin
            elapsed_next = '0;
        end
        if (step.ac_check)
        begin
            enable_next = in_time;
        end
    end

    acpc_phase_ctrl u_phase
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cfg           (cfg_reg),
        .output_enable (enable_reg),
        .pin_next      (phase_pin_next),
        .phase_next    (phase_next)
    );

    acpc_cycle_ctrl u_cycle
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .denominator   (cfg_reg.cycle_ratio_denominator),
        .output_enable (enable_reg),
        .pin_next      (cycle_pin_next)
    );

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mains_is_60hz           <= 1'b0;
            cfg_reg.zero_cross_lead         <= '0;
            cfg_reg.triac_pulse_ticks       <= 16'd200;
            cfg_reg.cycle_ratio_denominator <= 7'd100;
            cfg_reg.ac_timeout_ticks        <= 24'd200000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                acpc_pkg::CFG_MAINS_60HZ:
                    cfg_reg.mains_is_60hz <= cfg.data[0];
                acpc_pkg::CFG_LEAD:
                    cfg_reg.zero_cross_lead <= cfg.data[acpc_pkg::LEAD_W-1:0];
                acpc_pkg::CFG_PULSE_TICKS:
                    cfg_reg.triac_pulse_ticks <= cfg.data[acpc_pkg::TIMER_W-1:0];
                acpc_pkg::CFG_DENOMINATOR:
                    cfg_reg.cycle_ratio_denominator <= cfg.data[acpc_pkg::PCT_W-1:0];
                acpc_pkg::CFG_TIMEOUT:
                    cfg_reg.ac_timeout_ticks <= cfg.data[acpc_pkg::TIMEOUT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // control flags and presence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            elapsed_reg   <= '0;
            enable_reg    <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            elapsed_reg <= elapsed_next;
            enable_reg  <= enable_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg   <= item.cmd;
            level_reg <= item.level;
        end
        if (advance)
        begin
            phase_drive_reg <= phase_pin_next;
            cycle_drive_reg <= cycle_pin_next;
            ac_present_reg  <= enable_next;
            phase_state_reg <= phase_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.phase_drive = phase_drive_reg;
    assign result.cycle_drive = cycle_drive_reg;
    assign result.ac_present  = ac_present_reg;
    assign result.phase_state = phase_state_reg;

endmodule
